>>> rtl/depq_pkg.sv
// Types and constants shared by the double-ended priority queue.
// No dependencies; imported by depq_cell and double_ended_priority_queue.
package depq_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned CountW = 7;

	// operation codes on the mode field
	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_DEL_MAX = 2'd1;
	localparam logic [1:0] MODE_DEL_MIN = 2'd2;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [ValueW-1:0] value;
	} depq_in_t;

	typedef struct packed {
		logic signed [ValueW-1:0] max_value;
		logic signed [ValueW-1:0] min_value;
		logic [CountW-1:0]        entry_count;
		logic                     is_empty;
		logic                     insert_dropped;
	} depq_out_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic                     ins;
		logic                     del_min;
		logic signed [ValueW-1:0] value;
	} depq_cmd_t;

endpackage

>>> rtl/depq_cell.sv
// One cell of the sorted row: holds one value of the ascending array.
// Depends on depq_pkg for the command type.
module depq_cell import depq_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 7
) (
	input  logic                     clk,
	input  depq_cmd_t                cmd,
	input  logic [CW-1:0]            count,
	input  logic                     left_gt,
	input  logic                     left_occ,
	input  logic signed [ValueW-1:0] left_val,
	input  logic signed [ValueW-1:0] right_val,
	output logic                     gt,
	output logic                     occ,
	output logic signed [ValueW-1:0] val,
	output logic signed [ValueW-1:0] top_val
);

	logic signed [ValueW-1:0] val_q;
	logic                     is_top;

	assign occ     = count > CW'(IDX);
	assign is_top  = count == CW'(IDX + 1);
	assign gt      = occ && (val_q > cmd.value);
	assign val     = val_q;
	assign top_val = is_top ? val_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			// shift larger entries up by one; drop the new value into the gap
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || (!occ && left_occ)) begin
				val_q <= cmd.value;
			end
		end else if (cmd.del_min) begin
			val_q <= right_val;
		end
	end

endmodule

>>> rtl/double_ended_priority_queue.sv
// Top level of the double-ended priority queue: a row of depq_cell instances
// plus the count, sequencing and result registers. Depends on depq_pkg.
//
// A double-ended priority queue of signed 32-bit values, kept in ascending
// order across a row of CAPACITY cells; duplicates are kept. An item is taken
// at a clock edge where start is high and busy is low. Each item is handled
// in order: at the accepting edge all cells shift or load at once (an insert
// moves every larger entry one cell up, a delete-minimum moves the whole row
// one cell down, a delete-maximum only lowers the count); in the next cycle,
// while busy is high, the new maximum is picked out of the row by the cell
// that sits at the top of the count and registered together with the minimum
// from cell zero. The result beat is then on result for exactly one cycle
// with done high, and a new item may be started in that same cycle; only the
// gather cycle refuses items. The receiver cannot hold results off:
// it must take the beat when done is high. A delete on an empty queue leaves
// the state as it is; an insert into a full queue is dropped and flagged by
// insert_dropped. An empty queue reports 0 as both maximum and minimum.
module double_ended_priority_queue import depq_pkg::*; #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  depq_in_t  item,
	output logic      done,
	output depq_out_t result
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// sequencer codes
	localparam logic PH_IDLE   = 1'b0;
	localparam logic PH_GATHER = 1'b1;

	logic                     phase_q;
	logic [CW-1:0]            count_q;
	logic                     drop_q;
	logic                     done_q;
	depq_out_t                result_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	depq_cmd_t                cmd;

	logic                     gts  [CAPACITY];
	logic                     occs [CAPACITY];
	logic signed [ValueW-1:0] vals [CAPACITY];
	logic signed [ValueW-1:0] tops [CAPACITY];
	logic signed [ValueW-1:0] max_sel;
	logic [CW+CountW-1:0]     count_ext;

	assign busy   = (phase_q == PH_GATHER);
	assign accept = start && !busy;
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	// drive the row only for operations that really change stored values
	assign cmd.ins     = accept && (item.mode == MODE_INSERT) && !full;
	assign cmd.del_min = accept && (item.mode == MODE_DEL_MIN) && !empty;
	assign cmd.value   = item.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     l_gt;
		logic                     l_occ;
		logic signed [ValueW-1:0] l_val;
		logic signed [ValueW-1:0] r_val;

		if (i == 0) begin : g_first
			assign l_gt  = 1'b0;
			assign l_occ = 1'b1;
			assign l_val = '0;
		end else begin : g_inner
			assign l_gt  = gts[i-1];
			assign l_occ = occs[i-1];
			assign l_val = vals[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign r_val = vals[i];
		end else begin : g_mid
			assign r_val = vals[i+1];
		end

		depq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.left_gt   (l_gt),
			.left_occ  (l_occ),
			.left_val  (l_val),
			.right_val (r_val),
			.gt        (gts[i]),
			.occ       (occs[i]),
			.val       (vals[i]),
			.top_val   (tops[i])
		);
	end

	// only the top cell passes its value, so an OR over the row picks the maximum
	always_comb begin
		max_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			max_sel = max_sel | tops[i];
		end
	end

	assign count_ext = {{CountW{1'b0}}, count_q};

	// hold the count, advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			drop_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				phase_q <= PH_GATHER;
				drop_q  <= (item.mode == MODE_INSERT) && full;
				if (cmd.ins) begin
					count_q <= count_q + CW'(1);
				end else if ((item.mode == MODE_DEL_MAX || item.mode == MODE_DEL_MIN)
						&& !empty) begin
					count_q <= count_q - CW'(1);
				end
			end else if (phase_q == PH_GATHER) begin
				phase_q <= PH_IDLE;
				done_q  <= 1'b1;
			end
		end
	end

	// result beat, registered at the end of the gather cycle
	always_ff @(posedge clk) begin
		if (phase_q == PH_GATHER) begin
			result_q.max_value      <= max_sel;
			result_q.min_value      <= empty ? '0 : vals[0];
			result_q.entry_count    <= count_ext[CountW-1:0];
			result_q.is_empty       <= empty;
			result_q.insert_dropped <= drop_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result beat always follows a gather cycle
	a_done_after_gather: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(phase_q == PH_GATHER))
		else $error("result beat without a gather cycle");

	a_gather_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("gather phase lasted more than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count exceeded capacity");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.insert_dropped |-> full)
		else $error("insert flagged as dropped while queue not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == empty))
		else $error("empty flag disagrees with count");

endmodule

>>> tb/sv/double_ended_priority_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_priority_queue: a sorted shadow queue
// predicts every result beat. Depends on depq_pkg and the RTL of the queue.
module double_ended_priority_queue_tb import depq_pkg::*;;

	localparam int unsigned CAPACITY    = 64;
	localparam int          RANDOM_CMDS = 1060;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          SETTLE_CYC  = 8;

	// the fourth mode code has no operation behind it
	localparam logic [1:0] MODE_NOP = 2'd3;

	// shape of the random part: grow the queue, shrink it, or churn around a level
	typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_CHURN} stim_phase_t;

	// one pending command; wait_idle holds it back until every result is in
	typedef struct {
		logic     wait_idle;
		depq_in_t beat;
	} queued_cmd_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	depq_in_t  item_drv = '0;
	logic      done;
	depq_out_t result;

	double_ended_priority_queue #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item_drv),
		.done  (done),
		.result(result)
	);

	always #5 clk = ~clk;

	queued_cmd_t cmd_backlog[$];
	depq_out_t   expected_snapshots[$];

	// shadow of the queue contents, kept in ascending order
	logic signed [ValueW-1:0] shadow_vals[CAPACITY];
	int                       shadow_count = 0;

	// occupancy as seen while building the stimulus, to steer the phases
	int gen_count = 0;

	logic beat_taken = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   cycle_count = 0;
	int   mismatches = 0;
	int   cmds_taken = 0;
	int   results_seen = 0;
	int   drops_seen = 0;
	int   empties_seen = 0;
	int   full_seen = 0;

	// Apply one command to the shadow queue and return the snapshot it should report.
	function automatic depq_out_t apply_to_shadow(depq_in_t cmd);
		depq_out_t snap;
		int        pos;
		snap = '0;
		case (cmd.mode)
			MODE_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					snap.insert_dropped = 1'b1;
				end else begin
					// land after any equal entries, shift the larger ones up
					pos = shadow_count;
					while (pos > 0 && shadow_vals[pos-1] > cmd.value) begin
						shadow_vals[pos] = shadow_vals[pos-1];
						pos--;
					end
					shadow_vals[pos] = cmd.value;
					shadow_count++;
				end
			end
			MODE_DEL_MAX: begin
				if (shadow_count > 0)
					shadow_count--;
			end
			MODE_DEL_MIN: begin
				if (shadow_count > 0) begin
					for (int i = 0; i < shadow_count - 1; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		if (shadow_count == 0) begin
			snap.is_empty = 1'b1;
		end else begin
			snap.max_value = shadow_vals[shadow_count-1];
			snap.min_value = shadow_vals[0];
		end
		snap.entry_count = CountW'(shadow_count);
		return snap;
	endfunction

	function automatic logic signed [ValueW-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1: begin
				// the edges of the signed range and their neighbours
				case ($urandom_range(0, 5))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sh7FFF_FFFE;
					3: return 32'sh8000_0001;
					4: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			2, 3, 4: begin
				// narrow band so duplicates pile up
				return $signed($urandom_range(0, 15)) - 32'sd8;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic push_cmd(logic [1:0] mode, logic signed [ValueW-1:0] value,
			logic wait_idle);
		queued_cmd_t qc;
		qc.wait_idle  = wait_idle;
		qc.beat.mode  = mode;
		qc.beat.value = value;
		cmd_backlog = {cmd_backlog, qc};
		case (mode)
			MODE_INSERT: begin
				if (gen_count < CAPACITY)
					gen_count++;
			end
			MODE_DEL_MAX, MODE_DEL_MIN: begin
				if (gen_count > 0)
					gen_count--;
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(string name, logic signed [ValueW-1:0] want,
			logic signed [ValueW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: change inputs on the falling edge only. A beat taken at the last
	// rising edge leaves the backlog; then either hold off for the gap or offer
	// the next command. start gets one assignment per edge, so a back-to-back
	// beat keeps start high rather than dropping and raising it.
	always @(negedge clk) begin : driver
		logic     nxt_start;
		depq_in_t nxt_item;
		nxt_start = start;
		nxt_item  = item_drv;
		if (arst_n) begin
			if (beat_taken) begin
				void'(cmd_backlog.pop_front());
				nxt_start = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			if (!nxt_start && cmd_backlog.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!cmd_backlog[0].wait_idle
						|| expected_snapshots.size() == 0) begin
					nxt_start = 1'b1;
					nxt_item  = cmd_backlog[0].beat;
				end
			end
		end
		start    <= nxt_start;
		item_drv <= nxt_item;
	end

	// Monitor: sample on the rising edge. Check a result beat against the oldest
	// snapshot first, then predict for a command taken at this same edge; the
	// result for that command cannot arrive before the next edge.
	always @(posedge clk) begin : monitor
		depq_out_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (result.insert_dropped)
					drops_seen++;
				if (result.is_empty)
					empties_seen++;
				if (result.entry_count == CountW'(CAPACITY))
					full_seen++;
				if (expected_snapshots.size() == 0) begin
					$error("result beat with nothing expected: max %0d min %0d count %0d",
						result.max_value, result.min_value, result.entry_count);
					mismatches++;
				end else begin
					want = expected_snapshots.pop_front();
					check_field("max_value", want.max_value, result.max_value);
					check_field("min_value", want.min_value, result.min_value);
					check_field("entry_count", ValueW'(want.entry_count),
						ValueW'(result.entry_count));
					check_field("is_empty", ValueW'(want.is_empty),
						ValueW'(result.is_empty));
					check_field("insert_dropped", ValueW'(want.insert_dropped),
						ValueW'(result.insert_dropped));
				end
			end
			if (start && !busy) begin
				expected_snapshots = {expected_snapshots, apply_to_shadow(item_drv)};
				cmds_taken++;
			end
			beat_taken <= start && !busy;
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d commands still queued, %0d results owed",
				cycle_count, cmd_backlog.size(), expected_snapshots.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : sequencer
		stim_phase_t phase;
		int          phase_left;
		int          random_made;
		int          roll;
		int          ins_pct;
		logic [1:0]  mode;
		logic        hold;

		phase       = PH_CHURN;
		phase_left  = 0;
		random_made = 0;

		// Directed: deletes and a no-op on an empty queue, the signed extremes,
		// duplicates, then peel from both ends down to empty and past it.
		push_cmd(MODE_DEL_MAX, 32'sd0, 1'b0);
		push_cmd(MODE_DEL_MIN, 32'sd0, 1'b0);
		push_cmd(MODE_NOP, -32'sd1, 1'b0);
		push_cmd(MODE_INSERT, 32'sh7FFF_FFFF, 1'b0);
		push_cmd(MODE_INSERT, 32'sh8000_0000, 1'b0);
		push_cmd(MODE_INSERT, 32'sd0, 1'b0);
		push_cmd(MODE_INSERT, -32'sd1, 1'b0);
		push_cmd(MODE_INSERT, -32'sd1, 1'b0);
		push_cmd(MODE_INSERT, 32'sh7FFF_FFFF, 1'b0);
		push_cmd(MODE_NOP, 32'sh5A5A_A5A5, 1'b0);
		push_cmd(MODE_DEL_MAX, 32'sh7FFF_FFFF, 1'b0);
		push_cmd(MODE_DEL_MIN, -32'sd1, 1'b0);
		push_cmd(MODE_DEL_MAX, 32'sd0, 1'b0);
		push_cmd(MODE_DEL_MIN, 32'sd0, 1'b0);
		push_cmd(MODE_DEL_MAX, 32'sd0, 1'b0);
		push_cmd(MODE_DEL_MIN, 32'sd0, 1'b0);
		push_cmd(MODE_DEL_MIN, 32'sd0, 1'b0);
		push_cmd(MODE_INSERT, 32'sd5, 1'b0);
		push_cmd(MODE_DEL_MIN, 32'sd0, 1'b0);
		push_cmd(MODE_INSERT, -32'sd3, 1'b0);
		push_cmd(MODE_DEL_MAX, 32'sd0, 1'b0);

		// Fill to capacity after a full drain, push two beyond it, then free a
		// slot, refill it and overflow once more.
		for (int i = 0; i < CAPACITY; i++)
			push_cmd(MODE_INSERT, pick_value(), i == 0);
		push_cmd(MODE_INSERT, pick_value(), 1'b0);
		push_cmd(MODE_INSERT, 32'sh8000_0000, 1'b0);
		push_cmd(MODE_NOP, pick_value(), 1'b0);
		push_cmd(MODE_DEL_MAX, pick_value(), 1'b0);
		push_cmd(MODE_INSERT, pick_value(), 1'b0);
		push_cmd(MODE_INSERT, pick_value(), 1'b0);

		// Random: phases of steered occupancy with random values; the odd no-op
		// and the odd drain to idle mixed in.
		while (random_made < RANDOM_CMDS) begin
			if (phase_left == 0) begin
				phase      = stim_phase_t'($urandom_range(0, 2));
				phase_left = $urandom_range(20, 100);
			end
			phase_left--;
			case (phase)
				PH_FILL:  ins_pct = 85;
				PH_DRAIN: ins_pct = 15;
				default:  ins_pct = (gen_count < 8) ? 70 : 50;
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 4)
				mode = MODE_NOP;
			else if ($urandom_range(0, 99) < ins_pct)
				mode = MODE_INSERT;
			else
				mode = $urandom_range(0, 1) ? MODE_DEL_MAX : MODE_DEL_MIN;
			hold = ($urandom_range(0, 199) == 0) || (random_made == RANDOM_CMDS / 2);
			push_cmd(mode, pick_value(), hold);
			random_made++;
		end

		// hold reset, then release it away from the sampling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: all commands taken and every snapshot matched, then settle
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || start || expected_snapshots.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);

		$display("Ran %0d commands, checked %0d result beats in %0d cycles.",
			cmds_taken, results_seen, cycle_count);
		$display("Saw the queue full %0d times, %0d inserts refused, %0d empty reports.",
			full_seen, drops_seen, empties_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
